// ----- rtl/spimbs_pkg.sv -----
// ----------------------------------------------------------------------------
// spimbs_pkg
// Shared types and constants of the SPI master bit sequencer.
// ----------------------------------------------------------------------------
package spimbs_pkg;

    localparam int unsigned CHANNELS_DEF    = 4;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned HALF_BITS     = 2 * BITS_PER_BYTE;
    localparam int unsigned HALF_CNT_W    = $clog2(HALF_BITS);
    localparam int unsigned LINES         = 4;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_VAL_W = 4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLARITY     = 2'd0,
        REG_SELECT_MASK  = 2'd1,
        REG_COMMAND_MASK = 2'd2
    } cfg_reg_t;

    // request codes on the mode field
    typedef enum logic [2:0] {
        MODE_TICK  = 3'd0,
        MODE_OPEN  = 3'd1,
        MODE_CMD   = 3'd2,
        MODE_DATA  = 3'd3,
        MODE_READ  = 3'd4,
        MODE_CLOSE = 3'd5
    } mode_t;

    // classified operation, one-hot
    typedef enum logic [5:0] {
        OP_TICK  = 6'b000001,
        OP_OPEN  = 6'b000010,
        OP_CMD   = 6'b000100,
        OP_DATA  = 6'b001000,
        OP_READ  = 6'b010000,
        OP_CLOSE = 6'b100000
    } op_t;

    // byte in progress, one-hot
    typedef enum logic [3:0] {
        KIND_IDLE = 4'b0001,
        KIND_CMD  = 4'b0010,
        KIND_DATA = 4'b0100,
        KIND_READ = 4'b1000
    } kind_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] channel;
        logic [7:0] byte_value;
        logic       data_in_level;
    } req_t;

    typedef struct packed {
        logic             serial_clock;
        logic             data_out;
        logic [LINES-1:0] select_lines_n;
        logic [LINES-1:0] command_lines_n;
        logic             accepted;
        logic             busy_res;
        logic [7:0]       read_byte;
        logic             read_valid;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_VAL_W-1:0] value;
    } cfg_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] channel;
        logic [7:0] byte_value;
        logic       data_in_level;
    } entry_t;

endpackage

// ----- rtl/spimbs_if.sv -----
// ----------------------------------------------------------------------------
// spimbs_if
// Valid/ready channels of the SPI master bit sequencer.
// ----------------------------------------------------------------------------
interface spimbs_req_if;
    logic              valid;
    logic              ready;
    spimbs_pkg::req_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spimbs_rsp_if;
    logic              valid;
    logic              ready;
    spimbs_pkg::rsp_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spimbs_cfg_if;
    logic              valid;
    logic              ready;
    spimbs_pkg::cfg_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spimbs_entry_if;
    logic                valid;
    logic                ready;
    spimbs_pkg::entry_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/spimbs_front.sv -----
// ----------------------------------------------------------------------------
// spimbs_front
// Takes request words and classifies the mode into a one-hot operation.
// ----------------------------------------------------------------------------
module spimbs_front (
    spimbs_req_if.sink     req,
    spimbs_entry_if.source q
);
    import spimbs_pkg::*;

    op_t op;

    always_comb
    begin
        case (req.data.mode)
            MODE_OPEN:  op = OP_OPEN;
            MODE_CMD:   op = OP_CMD;
            MODE_DATA:  op = OP_DATA;
            MODE_READ:  op = OP_READ;
            MODE_CLOSE: op = OP_CLOSE;
            // unused codes act as a plain tick
            default:    op = OP_TICK;
        endcase
    end

    assign q.valid              = req.valid;
    assign req.ready            = q.ready;
    assign q.data.op            = op;
    assign q.data.channel       = req.data.channel;
    assign q.data.byte_value    = req.data.byte_value;
    assign q.data.data_in_level = req.data.data_in_level;

endmodule

// ----- rtl/spimbs_queue.sv -----
// ----------------------------------------------------------------------------
// spimbs_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module spimbs_queue #(
    parameter int unsigned DEPTH = spimbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    spimbs_entry_if.sink   push,
    spimbs_entry_if.source pop
);
    import spimbs_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push_fire, pop_fire;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign push.ready = (count_reg != CNT_W'(DEPTH));
    assign pop.valid  = (count_reg != '0);
    assign pop.data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push.valid && push.ready;
    assign pop_fire   = pop.valid && pop.ready;

    always_comb
    begin
        wr_ptr_next = push_fire ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop_fire ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire && !pop_fire)
            count_next = count_reg + 1'b1;
        else if (pop_fire && !push_fire)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slot_reg[wr_ptr_reg] <= push.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/spimbs_back.sv -----
// ----------------------------------------------------------------------------
// spimbs_back
// Executes one half-bit tick per word and registers the pin levels.
// ----------------------------------------------------------------------------
module spimbs_back #(
    parameter int unsigned CHANNELS = spimbs_pkg::CHANNELS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    spimbs_cfg_if.sink    cfg,
    spimbs_entry_if.sink  q,
    spimbs_rsp_if.source  rsp
);
    import spimbs_pkg::*;

    // configuration
    logic             pol_reg;
    logic [LINES-1:0] sel_en_reg;
    logic [LINES-1:0] cmd_en_reg;

    // sequencer state
    kind_t                 kind_reg, kind_next;
    logic [7:0]            shift_reg, shift_next;
    logic [HALF_CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]            chan_reg, chan_next;
    logic                  frame_reg, frame_next;
    logic                  sclk_reg, sclk_next;
    logic                  dout_reg, dout_next;
    logic                  cmd_phase_reg, cmd_phase_next;

    // output register
    logic                  out_valid_reg;
    rsp_t                  out_reg, out_next;

    logic                  pop;
    logic                  accepted;
    logic                  rvalid;
    logic [7:0]            rbyte;

    function automatic logic [LINES-1:0] line_mask(
        input logic [LINES-1:0] enable,
        input logic             on,
        input logic [1:0]       chan
    );
        logic [LINES-1:0] lines;
        lines = '1;
        if (on && ({1'b0, chan} < 3'(CHANNELS)) && enable[chan])
            lines[chan] = 1'b0;
        return lines;
    endfunction

    assign cfg.ready = 1'b1;
    assign pop       = q.valid && (!out_valid_reg || rsp.ready);
    assign q.ready   = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        kind_next      = kind_reg;
        shift_next     = shift_reg;
        cnt_next       = cnt_reg;
        chan_next      = chan_reg;
        frame_next     = frame_reg;
        sclk_next      = sclk_reg;
        dout_next      = dout_reg;
        cmd_phase_next = cmd_phase_reg;
        accepted       = 1'b0;
        rvalid         = 1'b0;
        rbyte          = '0;

        // take a request only between bytes
        if (kind_reg == KIND_IDLE)
        begin
            case (q.data.op)
                OP_OPEN:
                begin
                    chan_next      = q.data.channel;
                    frame_next     = 1'b1;
                    cmd_phase_next = 1'b0;
                    sclk_next      = pol_reg;
                    accepted       = 1'b1;
                end
                OP_CMD:
                begin
                    shift_next     = q.data.byte_value;
                    kind_next      = KIND_CMD;
                    cnt_next       = '0;
                    cmd_phase_next = 1'b1;
                    accepted       = 1'b1;
                end
                OP_DATA:
                begin
                    shift_next     = q.data.byte_value;
                    kind_next      = KIND_DATA;
                    cnt_next       = '0;
                    cmd_phase_next = 1'b0;
                    accepted       = 1'b1;
                end
                OP_READ:
                begin
                    kind_next      = KIND_READ;
                    cnt_next       = '0;
                    cmd_phase_next = 1'b0;
                    accepted       = 1'b1;
                end
                OP_CLOSE:
                begin
                    frame_next     = 1'b0;
                    cmd_phase_next = 1'b0;
                    sclk_next      = pol_reg;
                    accepted       = 1'b1;
                end
                default:
                begin
                    cmd_phase_next = 1'b0;
                    sclk_next      = pol_reg;
                end
            endcase
        end

        // the accepting tick also runs the first half-bit
        if (kind_next != KIND_IDLE)
        begin
            if (!cnt_next[0])
            begin
                sclk_next = pol_reg;
                if (kind_next == KIND_READ)
                    shift_next = {shift_next[6:0], q.data.data_in_level};
                dout_next = shift_next[7];
            end
            else
            begin
                sclk_next = !pol_reg;
                if (kind_next != KIND_READ)
                    shift_next = {shift_next[6:0], 1'b0};
            end
            if (cnt_next == HALF_CNT_W'(HALF_BITS - 1))
            begin
                if (kind_next == KIND_READ)
                begin
                    rvalid = 1'b1;
                    rbyte  = shift_next;
                end
                kind_next = KIND_IDLE;
                cnt_next  = '0;
            end
            else
            begin
                cnt_next = cnt_next + 1'b1;
            end
        end

        out_next.serial_clock    = sclk_next;
        out_next.data_out        = dout_next;
        out_next.select_lines_n  = line_mask(sel_en_reg, frame_next, chan_next);
        out_next.command_lines_n = line_mask(cmd_en_reg, cmd_phase_next, chan_next);
        out_next.accepted        = accepted;
        out_next.busy_res        = (kind_next != KIND_IDLE);
        out_next.read_byte       = rbyte;
        out_next.read_valid      = rvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg    <= 1'b0;
            sel_en_reg <= '0;
            cmd_en_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.data.index)
                REG_POLARITY:     pol_reg    <= cfg.data.value[0];
                REG_SELECT_MASK:  sel_en_reg <= cfg.data.value[LINES-1:0];
                REG_COMMAND_MASK: cmd_en_reg <= cfg.data.value[LINES-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_IDLE;
            shift_reg     <= '0;
            cnt_reg       <= '0;
            chan_reg      <= '0;
            frame_reg     <= 1'b0;
            sclk_reg      <= 1'b0;
            dout_reg      <= 1'b0;
            cmd_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                kind_reg      <= kind_next;
                shift_reg     <= shift_next;
                cnt_reg       <= cnt_next;
                chan_reg      <= chan_next;
                frame_reg     <= frame_next;
                sclk_reg      <= sclk_next;
                dout_reg      <= dout_next;
                cmd_phase_reg <= cmd_phase_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result word until it is taken
    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= out_next;
    end

endmodule

// ----- rtl/spi_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// spi_master_bit_sequencer
// SPI master driven one half-bit tick per request word.
//
//   channel | dir | payload                                    | handshake
//   req     | in  | mode, channel, byte_value, data_in_level   | valid/ready
//   rsp     | out | pin levels, accepted, busy, read byte      | valid/ready
//   cfg     | in  | index, value (polarity, select/cmd masks)  | valid/ready
//
// One request word in and one result word out per cycle when neither side
// stalls; the tick state updates in the back stage.
// A word passes through the request queue and then the output register.
// Reset clears all control and config registers at once; no clearing pass, cfg.ready is always high.
// A stall on rsp fills the queue, then drops req.ready; words are never lost.
// ----------------------------------------------------------------------------
module spi_master_bit_sequencer #(
    parameter int unsigned CHANNELS    = spimbs_pkg::CHANNELS_DEF,
    parameter int unsigned QUEUE_DEPTH = spimbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    spimbs_req_if.sink    req,
    spimbs_rsp_if.source  rsp,
    spimbs_cfg_if.sink    cfg
);
    import spimbs_pkg::*;

    spimbs_entry_if q_push ();
    spimbs_entry_if q_pop ();

    spimbs_front u_front (
        .req (req),
        .q   (q_push)
    );

    spimbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .pop   (q_pop)
    );

    spimbs_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .q     (q_pop),
        .rsp   (rsp)
    );

    // an accepted word is waiting in the queue on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> q_pop.valid)
        else $error("accepted request word missing from queue");

    // a received byte completes the byte, so busy must be clear
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.read_valid |-> !rsp.data.busy_res)
        else $error("read_valid while still busy");

    // read_byte stays zero unless a byte completes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.read_valid |-> rsp.data.read_byte == '0)
        else $error("read_byte nonzero without read_valid");

    // a taken request only happens between bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ready && rsp.data.busy_res ##1 rsp.valid
            |-> !rsp.data.accepted)
        else $error("request taken while a byte was in progress");

endmodule
